### sv/dsle_pkg.sv
// ----------------------------------------------------------------------------
// dsle_pkg
// Shared types and codes for the date-ordered entry table with expiry.
// ----------------------------------------------------------------------------
package dsle_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DATE_W  = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned PRICE_W = 32;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Input item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  // Packed date key: year, month, day (compares lexicographically as a number)
  typedef logic [DATE_W-1:0] date_t;

  typedef struct packed {
    date_t              date;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
  } entry_t;

  // Shared comparator flags
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

### sv/dsle_cmp.sv
// ----------------------------------------------------------------------------
// dsle_cmp
// Shared date comparator: flags a < b and a == b on packed date keys.
// ----------------------------------------------------------------------------
module dsle_cmp
  import dsle_pkg::*;
(
  input  date_t    a_i,
  input  date_t    b_i,
  output cmp_res_t res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

### sv/dsle_mem.sv
// ----------------------------------------------------------------------------
// dsle_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dsle_mem
  import dsle_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/date_sorted_list_with_expiry_core.sv
// ----------------------------------------------------------------------------
// date_sorted_list_with_expiry_core
// Date-ordered entry table (latest first) with sorted insert and cutoff expiry.
// ----------------------------------------------------------------------------
// Keeps up to DEPTH entries in one single-port-read memory, latest date first,
// walked by a small sequencer around one shared date comparator. One input
// beat is taken at a time; in_ready_o is high only while the sequencer idles,
// and a finished result may still sit in the output register meanwhile. The
// registered memory read means one read then one compare per entry touched,
// followed by the result register. An insert compares c stored entries, one
// more than the entries shifted down unless the new date is later than every
// stored date (c = 0 for an empty table); an insert into a full table gives
// status "full"; an expire reads all n stored entries, giving one beat per
// removed entry in table order with last_o on the final one, or a single
// "none" beat. Each of these stretches while out_ready_i is held low.
// Entries that stay keep their order. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module date_sorted_list_with_expiry_core
  import dsle_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [ID_W-1:0]      item_id_i,
  input  logic [DAY_W-1:0]     date_day_i,
  input  logic [MONTH_W-1:0]   date_month_i,
  input  logic [YEAR_W-1:0]    date_year_i,
  input  logic [PRICE_W-1:0]   price_bits_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [ID_W-1:0]      out_id_o,
  output logic [DAY_W-1:0]     out_day_o,
  output logic [MONTH_W-1:0]   out_month_o,
  output logic [YEAR_W-1:0]    out_year_o,
  output logic [PRICE_W-1:0]   out_price_o,
  output logic                 last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_FULL,
    S_EXP_RD,
    S_EXP_CMP,
    S_EXP_END
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   idx_q;      // walk position
  logic [CW-1:0]   kept_q;     // next write slot for surviving entries
  logic [CW-1:0]   count_q;    // valid entries
  date_t           key_q;      // entry date or cutoff
  logic [ID_W-1:0]    id_q;
  logic [PRICE_W-1:0] price_q;
  logic            pend_valid_q; // removed entry held back until last is known
  entry_t          pend_q;

  logic            out_valid_q;
  logic [1:0]      out_status_q;
  entry_t          out_entry_q;
  logic            out_last_q;

  logic [CW-1:0]   idx_m1;
  logic [CW-1:0]   idx_p1;
  logic            slot_free;
  logic            expired;
  logic            out_load;   // result register takes a new beat this cycle

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;
  cmp_res_t        cmp_res;

  assign idx_m1    = idx_q - 1'b1;
  assign idx_p1    = idx_q + 1'b1;
  assign slot_free = !out_valid_q || out_ready_i;
  assign expired   = cmp_res.lt || cmp_res.eq;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load  = slot_free &&
                     ((state_q == S_INS_PUT) || (state_q == S_FULL) ||
                      (state_q == S_EXP_END) ||
                      (state_q == S_EXP_CMP && expired && pend_valid_q));

  dsle_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // single comparator: stored date against the latched key
  dsle_cmp u_cmp (
    .a_i   (mem_rdata.date),
    .b_i   (key_q),
    .res_o (cmp_res)
  );

  // Memory control follows the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_m1[AW-1:0];
      end
      S_INS_CMP: begin
        // stored entry is earlier: move it down one slot
        if (cmp_res.lt) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[AW-1:0];
        end
      end
      S_INS_PUT: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[AW-1:0];
          mem_wdata = '{date: key_q, id: id_q, price: price_q};
        end
      end
      S_EXP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q[AW-1:0];
      end
      S_EXP_CMP: begin
        // survivor compacts towards the head; kept never passes the read point
        if (!expired) begin
          mem_we    = 1'b1;
          mem_waddr = kept_q[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      kept_q       <= '0;
      count_q      <= '0;
      key_q        <= '0;
      id_q         <= '0;
      price_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INSERTED;
      out_entry_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // beat taken and nothing new behind it
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            key_q   <= {date_year_i, date_month_i, date_day_i};
            id_q    <= item_id_i;
            price_q <= price_bits_i;
            if (kind_i == KIND_INSERT) begin
              idx_q <= count_q;
              if (count_q == DEPTH_C) begin
                state_q <= S_FULL;
              end else if (count_q == '0) begin
                state_q <= S_INS_PUT;
              end else begin
                state_q <= S_INS_RD;
              end
            end else begin
              idx_q        <= '0;
              kept_q       <= '0;
              pend_valid_q <= 1'b0;
              state_q      <= (count_q == '0) ? S_EXP_END : S_EXP_RD;
            end
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmp_res.lt) begin
            idx_q   <= idx_m1;
            state_q <= (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            state_q <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          if (slot_free) begin
            count_q      <= count_q + 1'b1;
            out_valid_q  <= 1'b1;
            out_status_q <= ST_INSERTED;
            out_entry_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_FULL: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= ST_FULL;
            out_entry_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_EXP_RD: begin
          state_q <= S_EXP_CMP;
        end
        S_EXP_CMP: begin
          if (expired) begin
            if (!pend_valid_q || slot_free) begin
              // a held entry is now known not to be the final one
              if (pend_valid_q) begin
                out_valid_q  <= 1'b1;
                out_status_q <= ST_EXPIRED;
                out_entry_q  <= pend_q;
                out_last_q   <= 1'b0;
              end
              pend_q       <= mem_rdata;
              pend_valid_q <= 1'b1;
              idx_q        <= idx_p1;
              state_q      <= (idx_p1 == count_q) ? S_EXP_END : S_EXP_RD;
            end
          end else begin
            kept_q  <= kept_q + 1'b1;
            idx_q   <= idx_p1;
            state_q <= (idx_p1 == count_q) ? S_EXP_END : S_EXP_RD;
          end
        end
        S_EXP_END: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b1;
            if (pend_valid_q) begin
              out_status_q <= ST_EXPIRED;
              out_entry_q  <= pend_q;
            end else begin
              out_status_q <= ST_NONE;
              out_entry_q  <= '0;
            end
            pend_valid_q <= 1'b0;
            count_q      <= kept_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_id_o    = out_entry_q.id;
  assign out_day_o   = out_entry_q.date[DAY_W-1:0];
  assign out_month_o = out_entry_q.date[DAY_W+MONTH_W-1:DAY_W];
  assign out_year_o  = out_entry_q.date[DATE_W-1:DAY_W+MONTH_W];
  assign out_price_o = out_entry_q.price;
  assign last_o      = out_last_q;

  // Assertions
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_kept_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= idx_q || state_q == S_IDLE || state_q == S_INS_RD ||
    state_q == S_INS_CMP || state_q == S_INS_PUT || state_q == S_FULL)
    else $error("compaction write overtook the read point");

  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("held expired entry left behind at idle");

  a_put_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_PUT) |-> (idx_q < DEPTH_C))
    else $error("insert slot beyond table");

endmodule
